// File: src/zce_pkg.sv
// ----------------------------------------------------------------------------
// zce_pkg: shared types and constants of the zero crossing edge marker
// Holds the configuration record, the control flags that travel with each
// item through the queue, register indexes, opcodes and reset values.
// ----------------------------------------------------------------------------
package zce_pkg;

   // Default geometry limits handed to the top level parameters.
   localparam int MAX_COLUMNS_DEF = 1024;
   localparam int SAMPLE_BITS_DEF = 16;

   // Depth of the queue between the classifier and the datapath.
   localparam int QUEUE_DEPTH = 4;

   // Configuration port geometry.
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_COLUMNS = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_ROWS    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FG_VALUE      = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BG_VALUE      = 2'd3;

   // Item kinds carried in req_tuser.
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // Register reset values.
   localparam logic [10:0] FRAME_COLUMNS_RST = 11'd640;
   localparam logic [15:0] FRAME_ROWS_RST    = 16'd480;
   localparam logic [7:0]  FG_VALUE_RST      = 8'd255;
   localparam logic [7:0]  BG_VALUE_RST      = 8'd0;

   typedef struct packed {
      logic [10:0] frame_columns;
      logic [15:0] frame_rows;
      logic [7:0]  fg_value;
      logic [7:0]  bg_value;
   } cfg_type;

   // Flags decided by the classifier for one queued item.
   typedef struct packed {
      logic drain;     // drain item: no window or line store update
      logic emit;      // item produces a label
      logic interior;  // labeled pixel is off the border
      logic last;      // final label of the frame
   } ctrl_type;

   localparam int CTRL_BITS = $bits(ctrl_type);

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// File: src/zce_front.sv
// ----------------------------------------------------------------------------
// zce_front: item classifier
// Tracks the raster position and the drain count, decides for each accepted
// item whether it yields a label and whether that label lies on the border.
// ----------------------------------------------------------------------------
module zce_front #(
   parameter int MAX_COLUMNS = zce_pkg::MAX_COLUMNS_DEF,
   parameter int SAMPLE_BITS = zce_pkg::SAMPLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  zce_pkg::cfg_type       cfg,
   input  logic                   accept,
   input  logic                   opcode,
   input  logic [SAMPLE_BITS-1:0] sample,
   output logic                   push,
   output logic [zce_pkg::CTRL_BITS+$clog2(MAX_COLUMNS)+SAMPLE_BITS-1:0] push_data
);

   localparam int CB  = $clog2(MAX_COLUMNS);
   localparam int WB  = $clog2(MAX_COLUMNS + 1);
   localparam int EW  = (WB > 11) ? WB : 11;
   localparam int PW  = EW + 1;

   logic [CB-1:0] col_ff, col_in;
   logic [15:0]   row_ff, row_in;
   logic [PW-1:0] pend_ff, pend_in;

   logic [EW-1:0]     eff_w;
   logic [15:0]       eff_h;
   logic [EW-1:0]     c;
   logic [EW-1:0]     c_next;
   logic [16:0]       r_wide;
   logic [15:0]       r;
   logic              end_of_frame;
   zce_pkg::ctrl_type ctrl;

   // Effective geometry: zero acts as one, columns cap at the line store depth.
   always_comb begin
      if (cfg.frame_columns == 11'd0) begin
         eff_w = EW'(1);
      end else if (EW'(cfg.frame_columns) > EW'(MAX_COLUMNS)) begin
         eff_w = EW'(MAX_COLUMNS);
      end else begin
         eff_w = EW'(cfg.frame_columns);
      end
      eff_h = (cfg.frame_rows == 16'd0) ? 16'd1 : cfg.frame_rows;
   end

   always_comb begin
      c      = EW'(col_ff);
      r_wide = {1'b0, row_ff};
      if (c >= eff_w) begin
         c      = '0;
         r_wide = r_wide + 17'd1;
      end
      if (r_wide >= {1'b0, eff_h}) begin
         r_wide = '0;
      end
      r = r_wide[15:0];
      c_next = c + EW'(1);
      end_of_frame = (r == eff_h - 16'd1) && (c == eff_w - EW'(1));

      col_in  = col_ff;
      row_in  = row_ff;
      pend_in = pend_ff;
      push    = 1'b0;
      ctrl    = '0;

      if (accept) begin
         if (opcode == zce_pkg::OP_DRAIN) begin
            if (pend_ff != '0) begin
               push       = 1'b1;
               pend_in    = pend_ff - PW'(1);
               ctrl.drain = 1'b1;
               ctrl.emit  = 1'b1;
               ctrl.last  = (pend_ff == PW'(1));
            end
         end else begin
            push          = 1'b1;
            ctrl.emit     = (r >= 16'd2) || ((r == 16'd1) && (c != '0));
            ctrl.interior = (r >= 16'd2) && (c >= EW'(2));
            if (end_of_frame) begin
               col_in  = '0;
               row_in  = '0;
               pend_in = (eff_h >= 16'd2) ? PW'(eff_w) + PW'(1) : PW'(eff_w);
            end else begin
               pend_in = '0;
               if (c_next >= eff_w) begin
                  col_in = '0;
                  row_in = r + 16'd1;
               end else begin
                  col_in = c_next[CB-1:0];
                  row_in = r;
               end
            end
         end
      end
      push_data = {ctrl, c[CB-1:0], sample};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         pend_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         pend_ff <= pend_in;
      end
   end

endmodule

// File: src/zce_queue.sv
// ----------------------------------------------------------------------------
// zce_queue: small synchronous queue
// Decouples the classifier from the datapath so either side can stall.
// ----------------------------------------------------------------------------
module zce_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = zce_pkg::QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [WIDTH-1:0]         push_data,
   input  logic                     pop,
   output logic [WIDTH-1:0]         head_data,
   output zce_pkg::queue_status_type status
);

   localparam int AB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NB = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AB-1:0]    wr_ff, wr_in;
   logic [AB-1:0]    rd_ff, rd_in;
   logic [NB-1:0]    count_ff, count_in;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == AB'(DEPTH - 1)) ? '0 : wr_ff + AB'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == AB'(DEPTH - 1)) ? '0 : rd_ff + AB'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + NB'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NB'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   assign head_data    = slot_ff[rd_ff];
   assign status.full  = (count_ff == NB'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

// File: src/zce_back.sv
// ----------------------------------------------------------------------------
// zce_back: line store, 3x3 window and label datapath
// Reads the two stored rows for each pixel, shifts the window, tests the
// window center for a zero crossing and holds the label in the output stage.
// ----------------------------------------------------------------------------
module zce_back #(
   parameter int MAX_COLUMNS = zce_pkg::MAX_COLUMNS_DEF,
   parameter int SAMPLE_BITS = zce_pkg::SAMPLE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  zce_pkg::cfg_type         cfg,
   input  logic [zce_pkg::CTRL_BITS+$clog2(MAX_COLUMNS)+SAMPLE_BITS-1:0] head_data,
   input  zce_pkg::queue_status_type q_status,
   output logic                     pop,
   output logic                     clearing,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [7:0]               rsp_tdata,
   output logic                     rsp_tlast
);

   localparam int CB = $clog2(MAX_COLUMNS);
   localparam int SB = SAMPLE_BITS;

   // Line store entry: upper row sample in the high half, middle row below.
   logic [2*SB-1:0] mem [MAX_COLUMNS];

   zce_pkg::ctrl_type hd_ctrl;
   logic [CB-1:0]     hd_col;
   logic [SB-1:0]     hd_sample;

   logic              clear_ff;
   logic [CB-1:0]     clr_ff;

   logic              s2_valid_ff;
   zce_pkg::ctrl_type s2_ctrl_ff;
   logic [CB-1:0]     s2_col_ff;
   logic [SB-1:0]     s2_sample_ff;
   logic [2*SB-1:0]   rd_ff;
   logic              fwd_ff;
   logic [2*SB-1:0]   fwd_data_ff;

   logic              s3_valid_ff;
   zce_pkg::ctrl_type s3_ctrl_ff;

   logic signed [SB-1:0] win_ff [3][3];

   logic              rsp_valid_ff;
   logic [7:0]        rsp_label_ff;
   logic              rsp_last_ff;

   logic              adv;
   logic              s2_write;
   logic [2*SB-1:0]   old_entry;
   logic [2*SB-1:0]   new_entry;
   logic              crossing;

   assign {hd_ctrl, hd_col, hd_sample} = head_data;

   // The whole datapath moves together whenever the output stage can take a label.
   assign adv      = !rsp_valid_ff || rsp_tready;
   assign pop      = adv && !q_status.empty && !clear_ff;
   assign clearing = clear_ff;

   assign old_entry = fwd_ff ? fwd_data_ff : rd_ff;
   assign new_entry = {old_entry[SB-1:0], s2_sample_ff};
   assign s2_write  = adv && s2_valid_ff && !s2_ctrl_ff.drain;

   function automatic logic [SB-1:0] mag(input logic signed [SB-1:0] v);
      logic [SB-1:0] n;
      n = SB'(-v);
      return v[SB-1] ? n : SB'(v);
   endfunction

   function automatic logic positive(input logic signed [SB-1:0] v);
      return !v[SB-1] && (v != '0);
   endfunction

   always_comb begin
      logic signed [SB-1:0] ctr;
      logic signed [SB-1:0] nb;
      ctr      = win_ff[1][1];
      crossing = 1'b0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            nb = win_ff[i][j];
            if (!(i == 1 && j == 1)) begin
               if (ctr == '0) begin
                  if (nb != '0) begin
                     crossing = 1'b1;
                  end
               end else if ((mag(ctr) < mag(nb)) && (positive(ctr) != positive(nb))) begin
                  crossing = 1'b1;
               end
            end
         end
      end
   end

   // Line store: clearing pass after reset, then one write per pixel.
   always_ff @(posedge clock) begin
      if (clear_ff) begin
         mem[clr_ff] <= '0;
      end else if (s2_write) begin
         mem[s2_col_ff] <= new_entry;
      end
      if (pop) begin
         rd_ff <= mem[hd_col];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff <= 1'b1;
         clr_ff   <= '0;
      end else if (clear_ff) begin
         clr_ff <= clr_ff + CB'(1);
         if (clr_ff == CB'(MAX_COLUMNS - 1)) begin
            clear_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff  <= pop;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff && s3_ctrl_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ctrl_ff   <= hd_ctrl;
         s2_col_ff    <= hd_col;
         s2_sample_ff <= hd_sample;
         // A write this edge to the entry being read is not seen by the read.
         fwd_ff       <= s2_write && (s2_col_ff == hd_col);
         fwd_data_ff  <= new_entry;
         s3_ctrl_ff   <= s2_ctrl_ff;
         rsp_label_ff <= (s3_ctrl_ff.interior && crossing) ? cfg.fg_value : cfg.bg_value;
         rsp_last_ff  <= s3_ctrl_ff.last;
      end
      if (s2_write) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i][0] <= win_ff[i][1];
            win_ff[i][1] <= win_ff[i][2];
         end
         win_ff[0][2] <= old_entry[2*SB-1:SB];
         win_ff[1][2] <= old_entry[SB-1:0];
         win_ff[2][2] <= s2_sample_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_label_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: src/zero_crossing_edge_marker.sv
// ----------------------------------------------------------------------------
// zero_crossing_edge_marker: 3x3 Laplacian zero crossing labeler
// Labels each pixel of a raster stream as foreground or background.
// ----------------------------------------------------------------------------
// Usage. Signed Laplacian samples enter on the req_ stream in raster order,
// req_tuser = 0. Each label leaves on the rsp_ stream one row plus one pixel
// of input later, so the first frame_columns + 1 samples of a frame yield no
// label. After the last sample of a frame, send drain items (req_tuser = 1)
// to release the remaining frame_columns + 1 labels (frame_columns for a
// single row), all background; the final one carries rsp_tlast. A drain
// with nothing pending yields nothing. Throughput is one item per clock
// while the output is not held. A label shows on rsp_tvalid once the queue
// has handed its item on and the line store is read, the window has
// shifted and the crossing test has filled the output register. Reset is
// synchronous; afterwards a pass over all MAX_COLUMNS entries zeroes the
// line store, with req_tready low meanwhile. The csr_ port can be written at
// any time, including during that pass. With a label waiting and rsp_tready
// low the datapath holds, the queue fills, and req_tready drops once full.
// ----------------------------------------------------------------------------
module zero_crossing_edge_marker #(
   parameter int MAX_COLUMNS = zce_pkg::MAX_COLUMNS_DEF,
   parameter int SAMPLE_BITS = zce_pkg::SAMPLE_BITS_DEF
) (
   input  logic clock,
   input  logic reset,

   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      req_tdata,  // sample, then zero fill
   input  logic                                  req_tuser,  // opcode

   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [7:0]                            rsp_tdata,  // label
   output logic                                  rsp_tlast,  // frame_last

   input  logic                                  csr_we,
   input  logic [zce_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [zce_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   localparam int EB = zce_pkg::CTRL_BITS + $clog2(MAX_COLUMNS) + SAMPLE_BITS;

   zce_pkg::cfg_type          cfg_ff;
   zce_pkg::queue_status_type q_status;
   logic                      accept;
   logic                      push;
   logic                      pop;
   logic                      clearing;
   logic [EB-1:0]             push_data;
   logic [EB-1:0]             head_data;

   // Configuration registers; all four indexes are defined.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_columns <= zce_pkg::FRAME_COLUMNS_RST;
         cfg_ff.frame_rows    <= zce_pkg::FRAME_ROWS_RST;
         cfg_ff.fg_value      <= zce_pkg::FG_VALUE_RST;
         cfg_ff.bg_value      <= zce_pkg::BG_VALUE_RST;
      end else if (csr_we) begin
         case (csr_index)
            zce_pkg::REG_FRAME_COLUMNS: cfg_ff.frame_columns <= csr_wdata[10:0];
            zce_pkg::REG_FRAME_ROWS:    cfg_ff.frame_rows    <= csr_wdata[15:0];
            zce_pkg::REG_FG_VALUE:      cfg_ff.fg_value      <= csr_wdata[7:0];
            zce_pkg::REG_BG_VALUE:      cfg_ff.bg_value      <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Input is held off while the line store is being cleared or the queue is full.
   assign req_tready = !q_status.full && !clearing;
   assign accept     = req_tvalid && req_tready;

   zce_front #(
      .MAX_COLUMNS(MAX_COLUMNS),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .accept   (accept),
      .opcode   (req_tuser),
      .sample   (req_tdata[SAMPLE_BITS-1:0]),
      .push     (push),
      .push_data(push_data)
   );

   zce_queue #(
      .WIDTH(EB),
      .DEPTH(zce_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .pop      (pop),
      .head_data(head_data),
      .status   (q_status)
   );

   zce_back #(
      .MAX_COLUMNS(MAX_COLUMNS),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head_data (head_data),
      .q_status  (q_status),
      .pop       (pop),
      .clearing  (clearing),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the zero crossing edge marker
// Streams signed Laplacian frames and drain items into the block, predicts
// every fg/bg label and frame end flag from its own copy of the line stores,
// the 3x3 window and the raster counters, and compares each label that
// leaves the block with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_LEN      = zce_pkg::MAX_COLUMNS_DEF;
   localparam int SETTLE_CYCLES = 8;       // well over the label latency
   localparam int LONG_HOLD     = 300;     // receiver hold that backs up the input
   localparam int ITEM_TARGET   = 1100;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int REPORT_MAX    = 20;

   // One item on the request stream: the opcode rides in tuser, the sample in
   // tdata.
   typedef struct packed {
      logic        kind;
      logic [15:0] value;
   } px_item_type;

   // One predicted label as it should leave on the response stream.
   typedef struct {
      logic [7:0] label;
      logic       last;
   } label_rec_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic        req_tuser  = zce_pkg::OP_PIXEL;

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;

   logic                               csr_we    = 1'b0;
   logic [zce_pkg::CSR_INDEX_BITS-1:0] csr_index = zce_pkg::REG_FRAME_COLUMNS;
   logic [zce_pkg::CSR_DATA_BITS-1:0]  csr_wdata = '0;

   zero_crossing_edge_marker u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Stimulus waiting for the driver, and labels waiting for the block.
   px_item_type   items_to_send[$];
   label_rec_type labels_due[$];

   // Shared knobs between the sequence, the monitor, the driver and the receiver.
   int  idle_pct      = 0;
   bit  stall_request = 1'b0;
   bit  req_taken     = 1'b0;

   // Bookkeeping for the summary and the verdict.
   int  mismatch_count = 0;
   int  items_accepted = 0;
   int  labels_checked = 0;
   int  fg_predicted   = 0;
   int  items_queued   = 0;
   int  phase_count    = 0;
   int  cycle_count    = 0;

   // ------------------------------------------------------------------------
   // Predictor state: register copies, line stores, window and counters.
   // ------------------------------------------------------------------------
   logic [10:0]        cfg_cols = zce_pkg::FRAME_COLUMNS_RST;
   logic [15:0]        cfg_rows = zce_pkg::FRAME_ROWS_RST;
   logic [7:0]         cfg_fg   = zce_pkg::FG_VALUE_RST;
   logic [7:0]         cfg_bg   = zce_pkg::BG_VALUE_RST;

   logic signed [15:0] upper_row  [LINE_LEN] = '{default: '0};
   logic signed [15:0] middle_row [LINE_LEN] = '{default: '0};
   logic signed [15:0] window_px  [3][3]     = '{default: '{default: '0}};
   int unsigned        col_pos     = 0;
   int unsigned        row_pos     = 0;
   int unsigned        owed_labels = 0;

   // A zero width or height behaves as one; anything wider than the line
   // store is clipped to its depth.
   function automatic int unsigned frame_width();
      if (cfg_cols == 0)
         return 1;
      if (cfg_cols > LINE_LEN)
         return LINE_LEN;
      return cfg_cols;
   endfunction

   function automatic int unsigned frame_height();
      return (cfg_rows == 0) ? 1 : cfg_rows;
   endfunction

   // A zero center crosses when any neighbor is nonzero. A nonzero center
   // crosses when a neighbor of the other sign ("> 0" versus not) is strictly
   // larger in magnitude.
   function automatic bit window_has_crossing();
      int ctr;
      int nb;
      ctr = window_px[1][1];
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if (i == 1 && j == 1)
               continue;
            nb = window_px[i][j];
            if (ctr == 0) begin
               if (nb != 0)
                  return 1'b1;
            end else if (((ctr < 0) ? -ctr : ctr) < ((nb < 0) ? -nb : nb) &&
                         ((ctr > 0) != (nb > 0))) begin
               return 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   // Advances the predicted state by one accepted item and queues the label
   // it releases, if any.
   function automatic void predict_item(input logic kind, input logic [15:0] raw);
      int unsigned   w;
      int unsigned   h;
      int unsigned   c;
      int unsigned   r;
      bit            fg;
      label_rec_type rec;
      w = frame_width();
      h = frame_height();
      if (kind == zce_pkg::OP_DRAIN) begin
         // A drain only releases a border label that the last frame still owes.
         if (owed_labels != 0) begin
            owed_labels--;
            rec.label = cfg_bg;
            rec.last  = (owed_labels == 0);
            labels_due.push_back(rec);
         end
         return;
      end
      // A new sample drops whatever the previous frame still owed.
      owed_labels = 0;
      c = col_pos;
      r = row_pos;
      // Counters left beyond a smaller geometry wrap before use.
      if (c >= w) begin
         c = 0;
         r++;
      end
      if (r >= h)
         r = 0;
      for (int i = 0; i < 3; i++) begin
         window_px[i][0] = window_px[i][1];
         window_px[i][1] = window_px[i][2];
      end
      window_px[0][2] = upper_row[c];
      window_px[1][2] = middle_row[c];
      window_px[2][2] = raw;
      upper_row[c]    = middle_row[c];
      middle_row[c]   = raw;
      // The window center trails the sample by one row and one pixel.
      if (r >= 2 || (r == 1 && c >= 1)) begin
         fg = 1'b0;
         if (c != 0 && r - 1 != 0 && r - 1 != h - 1 && c - 1 != 0 && c - 1 != w - 1)
            fg = window_has_crossing();
         rec.label = fg ? cfg_fg : cfg_bg;
         rec.last  = 1'b0;
         labels_due.push_back(rec);
         if (fg)
            fg_predicted++;
      end
      if (r == h - 1 && c == w - 1) begin
         owed_labels = (h >= 2) ? w + 1 : w;
         col_pos = 0;
         row_pos = 0;
      end else begin
         c++;
         if (c >= w) begin
            c = 0;
            r++;
         end
         col_pos = c;
         row_pos = r;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Clock, watchdog.
   // ------------------------------------------------------------------------
   initial begin
      forever #10 clock = ~clock;
   end

   // The limit is several times the slowest legal run: every item waiting out
   // the longest sender gap and receiver stall, plus the line store clearing
   // pass and the long receiver hold.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: no progress within %0d cycles", $time, CYCLE_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: samples both handshakes at the rising edge. The response is
   // checked before the request is predicted, so a label can never be matched
   // against an expectation created at the same edge.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            labels_checked++;
            if (labels_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("%0t: unexpected label, expected none, actual %0d last %0b",
                           $time, rsp_tdata, rsp_tlast);
            end else begin
               if (rsp_tdata !== labels_due[0].label) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_MAX)
                     $display("%0t: label mismatch, expected %0d, actual %0d",
                              $time, labels_due[0].label, rsp_tdata);
               end
               if (rsp_tlast !== labels_due[0].last) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_MAX)
                     $display("%0t: frame_last mismatch, expected %0b, actual %0b",
                              $time, labels_due[0].last, rsp_tlast);
               end
               void'(labels_due.pop_front());
            end
         end
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            items_accepted++;
            predict_item(req_tuser, req_tdata);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Driver: works at the falling edge. An offered item is held until the
   // monitor saw it accepted; otherwise the next item is taken from the queue
   // unless a random idle burst is running.
   // ------------------------------------------------------------------------
   int          send_gap = 0;
   px_item_type next_item;

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_taken)) begin
         if (send_gap == 0 && idle_pct != 0 && $urandom_range(99) < idle_pct)
            send_gap = $urandom_range(4, 1);
         if (send_gap != 0 || items_to_send.size() == 0) begin
            if (send_gap != 0)
               send_gap--;
            req_tvalid <= 1'b0;
         end else begin
            next_item = items_to_send.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= next_item.kind;
            req_tdata  <= next_item.value;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: random stalls, plus one long hold on request from the
   // sequence, counted here, that lets the block fill up and push back on
   // its input.
   // ------------------------------------------------------------------------
   int hold_left = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_request) begin
         stall_request = 1'b0;
         hold_left = LONG_HOLD - 1;
         rsp_tready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         hold_left = $urandom_range(3, 0);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // Sequence helpers.
   // ------------------------------------------------------------------------
   function automatic void queue_item(input logic kind, input logic [15:0] value);
      px_item_type it;
      it.kind  = kind;
      it.value = value;
      items_to_send.push_back(it);
      items_queued++;
   endfunction

   // Zeros and small values of both signs dominate so that crossings and
   // zero centers are common; extremes and full range values fill the rest.
   function automatic logic [15:0] pick_sample();
      int small_val;
      case ($urandom_range(9))
         0, 1, 2: return 16'h0000;
         3, 4, 5: begin
            small_val = int'($urandom_range(6)) - 3;
            return 16'(small_val);
         end
         6: begin
            case ($urandom_range(3))
               0:       return 16'h7FFF;
               1:       return 16'h8000;
               2:       return 16'hFFFF;
               default: return 16'h0001;
            endcase
         end
         default: return 16'($urandom);
      endcase
   endfunction

   // Writes one register at a falling edge and updates the predictor's copy
   // after the rising edge that took it. Only called while the block is idle.
   task automatic store_setting(input logic [zce_pkg::CSR_INDEX_BITS-1:0] idx,
                                input logic [15:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         zce_pkg::REG_FRAME_COLUMNS: cfg_cols = value[10:0];
         zce_pkg::REG_FRAME_ROWS:    cfg_rows = value;
         zce_pkg::REG_FG_VALUE:      cfg_fg   = value[7:0];
         zce_pkg::REG_BG_VALUE:      cfg_bg   = value[7:0];
         default: ;
      endcase
   endtask

   // Waits until nothing is queued, offered or expected, checked just after a
   // rising edge when all of those are settled, then lets a drain that yields
   // nothing run out of the pipeline.
   task automatic wait_idle();
      @(posedge clock);
      #1;
      while (items_to_send.size() != 0 || req_tvalid || labels_due.size() != 0) begin
         @(posedge clock);
         #1;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // A label value: the extremes often, anything otherwise, sometimes with
   // junk in the upper byte that the register must drop.
   function automatic logic [15:0] pick_label_word();
      logic [7:0] lo;
      logic [7:0] hi;
      case ($urandom_range(3))
         0:       lo = 8'h00;
         1:       lo = 8'hFF;
         default: lo = 8'($urandom);
      endcase
      hi = ($urandom_range(3) == 0) ? 8'($urandom) : 8'h00;
      return {hi, lo};
   endfunction

   // One random phase: new geometry, maybe new labels, then one to three frames.
   // Most frames are complete and drained exactly; the rest are cut short,
   // overrun, sprinkled with stray drains or drained too little or too much.
   task automatic run_random_phase();
      logic [10:0] cols;
      logic [15:0] rows;
      int unsigned w;
      int unsigned h;
      int unsigned npx;
      int unsigned ndr;
      int unsigned style;
      int          nfr;
      wait_idle();
      idle_pct = ($urandom_range(3) == 0) ? 0 : 30;
      if (items_queued > ITEM_TARGET * 8 / 10)
         idle_pct = 0;
      if ($urandom_range(7) == 0) begin
         cols = 11'($urandom_range(40, 20));
         rows = 16'($urandom_range(3, 1));
      end else begin
         case ($urandom_range(9))
            0:       cols = 11'd0;
            1:       cols = 11'd1;
            2:       cols = 11'd2;
            default: cols = 11'($urandom_range(12, 3));
         endcase
         case ($urandom_range(9))
            0:       rows = 16'd0;
            1:       rows = 16'd1;
            2:       rows = 16'd2;
            default: rows = 16'($urandom_range(6, 3));
         endcase
      end
      store_setting(zce_pkg::REG_FRAME_COLUMNS,
                    {(($urandom_range(3) == 0) ? 5'($urandom) : 5'd0), cols});
      store_setting(zce_pkg::REG_FRAME_ROWS, rows);
      if ($urandom_range(1) == 0)
         store_setting(zce_pkg::REG_FG_VALUE, pick_label_word());
      if ($urandom_range(1) == 0)
         store_setting(zce_pkg::REG_BG_VALUE, pick_label_word());
      nfr = $urandom_range(3, 1);
      repeat (nfr) begin
         w = frame_width();
         h = frame_height();
         style = $urandom_range(9);
         npx = (style < 8) ? w * h : $urandom_range(w * h + w, 1);
         for (int k = 0; k < npx; k++) begin
            if (style == 9 && $urandom_range(7) == 0)
               queue_item(zce_pkg::OP_DRAIN, 16'($urandom));
            queue_item(zce_pkg::OP_PIXEL, pick_sample());
         end
         ndr = (style < 6) ? ((h >= 2) ? w + 1 : w) : $urandom_range(w + 3, 0);
         repeat (ndr) queue_item(zce_pkg::OP_DRAIN, 16'($urandom));
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------------
   initial begin
      // Synchronous reset, released at a falling edge. The block then clears
      // its line stores and holds req_tready low meanwhile; the driver simply
      // waits on the handshake.
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: a 4x4 frame with distinctive labels. Its samples put a
      // zero center next to nonzero neighbors, opposite signs of larger and
      // smaller magnitude, and both ends of the sample range into the window.
      store_setting(zce_pkg::REG_FRAME_COLUMNS, 16'd4);
      store_setting(zce_pkg::REG_FRAME_ROWS, 16'd4);
      store_setting(zce_pkg::REG_FG_VALUE, 16'h00A5);
      store_setting(zce_pkg::REG_BG_VALUE, 16'h005A);
      phase_count++;
      idle_pct = 0;
      queue_item(zce_pkg::OP_PIXEL, 16'h0000);
      queue_item(zce_pkg::OP_PIXEL, 16'h0005);
      queue_item(zce_pkg::OP_PIXEL, 16'hFFFB);
      queue_item(zce_pkg::OP_PIXEL, 16'h7FFF);
      queue_item(zce_pkg::OP_PIXEL, 16'h0000);
      queue_item(zce_pkg::OP_PIXEL, 16'h0000);
      queue_item(zce_pkg::OP_PIXEL, 16'h0003);
      queue_item(zce_pkg::OP_PIXEL, 16'h8000);
      queue_item(zce_pkg::OP_PIXEL, 16'h0001);
      queue_item(zce_pkg::OP_PIXEL, 16'hFFFF);
      queue_item(zce_pkg::OP_PIXEL, 16'h0000);
      queue_item(zce_pkg::OP_PIXEL, 16'h0007);
      queue_item(zce_pkg::OP_PIXEL, 16'hFFF9);
      queue_item(zce_pkg::OP_PIXEL, 16'h0000);
      queue_item(zce_pkg::OP_PIXEL, 16'h0002);
      queue_item(zce_pkg::OP_PIXEL, 16'h0000);
      // Five owed border labels, the last one flagged, then a drain with
      // nothing left to release.
      repeat (6) queue_item(zce_pkg::OP_DRAIN, 16'hFFFF);

      // Random part, with a few fixed phases at the extremes of the geometry.
      while (items_queued < ITEM_TARGET || phase_count < 10) begin
         phase_count++;
         case (phase_count)
            3: begin
               // Widest setting, clipped to the line store depth, in a single
               // row that is cut short: nothing is owed, so the drains release
               // nothing, and the column counter is left far beyond the
               // geometry the next phase writes.
               wait_idle();
               store_setting(zce_pkg::REG_FRAME_COLUMNS, 16'h07FF);
               store_setting(zce_pkg::REG_FRAME_ROWS, 16'd1);
               repeat (200) queue_item(zce_pkg::OP_PIXEL, pick_sample());
               repeat (2) queue_item(zce_pkg::OP_DRAIN, 16'($urandom));
            end
            6: begin
               // Tallest setting: the frame never completes, so the counters
               // are left far beyond the geometry the next phase writes.
               wait_idle();
               store_setting(zce_pkg::REG_FRAME_COLUMNS, 16'd3);
               store_setting(zce_pkg::REG_FRAME_ROWS, 16'hFFFF);
               repeat (40) queue_item(zce_pkg::OP_PIXEL, pick_sample());
               repeat (3) queue_item(zce_pkg::OP_DRAIN, 16'($urandom));
            end
            8: begin
               // A 10x5 frame. Once labels are flowing the receiver holds off
               // for a long stretch while samples keep coming.
               wait_idle();
               store_setting(zce_pkg::REG_FRAME_COLUMNS, 16'd10);
               store_setting(zce_pkg::REG_FRAME_ROWS, 16'd5);
               repeat (20) queue_item(zce_pkg::OP_PIXEL, pick_sample());
               while (items_to_send.size() != 0) @(posedge clock);
               stall_request = 1'b1;
               repeat (30) queue_item(zce_pkg::OP_PIXEL, pick_sample());
               repeat (11) queue_item(zce_pkg::OP_DRAIN, 16'($urandom));
            end
            default: run_random_phase();
         endcase
      end

      // Quiet tail: no idling, then wait for the last label and some slack.
      idle_pct = 0;
      wait_idle();

      $display("Run covered %0d accepted items in %0d phases and %0d compared labels,",
               items_accepted, phase_count, labels_checked);
      $display("%0d of them crossings, over widths from zero up to one clipped to the line store.",
               fg_predicted);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
